// File: src/idsv_pkg.sv
// shared types, character codes, phase codes and the month length table
package idsv_pkg;

   localparam logic [3:0] MAX_FRACTION_DIGITS = 4'd9;
   localparam logic [5:0] MAX_TEXT            = 6'd35;
   localparam logic [5:0] POS_MAX             = 6'd63;

   // parse phases
   localparam logic [2:0] PH_DATE   = 3'd0;
   localparam logic [2:0] PH_TIME   = 3'd1;
   localparam logic [2:0] PH_AFTER  = 3'd2;
   localparam logic [2:0] PH_FRAC   = 3'd3;
   localparam logic [2:0] PH_ZULU   = 3'd4;
   localparam logic [2:0] PH_OFFSET = 3'd5;

   // result forms
   localparam logic [1:0] FORM_DATE   = 2'd0;
   localparam logic [1:0] FORM_TIME   = 2'd1;
   localparam logic [1:0] FORM_OFFSET = 2'd2;

   // ascii codes
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_Z     = 8'h5A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last;
   } req_payload_type;

   typedef struct packed {
      logic        valid_res;
      logic [1:0]  form;
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [29:0] fraction;
      logic [3:0]  fraction_digits;
      logic        offset_negative;
      logic [10:0] offset_minutes;
   } rsp_payload_type;

   typedef struct packed {
      logic [5:0]  position;
      logic [2:0]  phase;
      logic        failed;
      logic [13:0] year;
      logic [1:0]  year_mod4;    // running year mod 4
      logic [1:0]  cent_mod4;    // first two year digits mod 4
      logic        low_nonzero;  // last two year digits not both zero
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [29:0] frac;
      logic [3:0]  frac_count;
      logic [2:0]  ofs_pos;
      logic        ofs_sign;
      logic [4:0]  ofs_hour;
      logic [5:0]  ofs_minute;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '0;

   function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    days = 5'd30;
         4'd2:                                       days = leap ? 5'd29 : 5'd28;
         default:                                    days = 5'd0;
      endcase
      return days;
   endfunction

endpackage

// File: src/iso_datetime_stream_validator.sv
// top level: parse state register, step logic and result register
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_ready   req_payload (char_byte, last)
//  rsp      out        rsp_valid/rsp_ready   rsp_payload (decoded date-time)
//
// one byte is taken per cycle while req_ready is high; each byte goes through the combinational step logic
// the result of a final byte is in the result register the cycle after it is taken
// req_ready is low only while a result waits and rsp_ready is low
// reset clears the parse state and empties the result register
// the parse state returns to its reset value after every final byte
module iso_datetime_stream_validator
   import idsv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   parse_state_type state_ff;
   parse_state_type state_in;
   parse_state_type step_state;
   rsp_payload_type step_result;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   logic            req_take;

   idsv_step u_step (
      .st      (state_ff),
      .beat    (req_payload),
      .st_next (step_state),
      .result  (step_result)
   );

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_take  = req_valid & req_ready;

   always_comb begin
      state_in = state_ff;
      if (req_take) state_in = req_payload.last ? STATE_RESET : step_state;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (req_take && req_payload.last) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_payload.last) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_last_clears_state: assert property (@(posedge clock) disable iff (reset)
      req_take && req_payload.last |=> state_ff.position == 6'd0 && state_ff.phase == PH_DATE
                                       && !state_ff.failed)
      else $error("parse state not cleared after final beat");

   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take && req_payload.last |=> rsp_valid)
      else $error("final beat produced no result");

   a_position_holds: assert property (@(posedge clock) disable iff (reset)
      !req_take |=> $stable(state_ff.position))
      else $error("position moved without a beat");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.valid_res |-> rsp_payload.form == FORM_DATE
         && rsp_payload.year == 14'd0 && rsp_payload.month == 4'd0 && rsp_payload.day == 5'd0
         && rsp_payload.fraction == 30'd0 && rsp_payload.offset_minutes == 11'd0)
      else $error("invalid result carries nonzero fields");

endmodule

// File: src/idsv_step.sv
// per-byte parse step: next parse state and the decoded result for a final byte
module idsv_step
   import idsv_pkg::*;
(
   input  parse_state_type st,
   input  req_payload_type beat,
   output parse_state_type st_next,
   output rsp_payload_type result
);

   function automatic logic [9:0] acc10(input logic [9:0] a, input logic [3:0] d);
      return (a << 3) + (a << 1) + 10'(d);
   endfunction

   logic [7:0]  ch;
   logic [3:0]  dv;
   logic        is_dig;
   logic        is_z;
   logic        is_sign;
   logic [5:0]  pos;
   logic [13:0] year_x;
   logic [9:0]  month_x;
   logic [9:0]  day_x;
   logic [9:0]  hour_x;
   logic [9:0]  minute_x;
   logic [9:0]  second_x;
   logic [9:0]  ofs_hour_x;
   logic [9:0]  ofs_minute_x;
   logic [29:0] frac_x;
   logic        leap;
   logic        date_good;
   logic        ok;
   parse_state_type nx;
   logic        res_ok;
   logic [1:0]  res_form;

   assign ch      = beat.char_byte;
   assign dv      = ch[3:0];
   assign is_dig  = (ch >= CH_ZERO) && (ch <= CH_NINE);
   assign is_z    = (ch == CH_Z);
   assign is_sign = (ch == CH_PLUS) || (ch == CH_DASH);
   assign pos     = st.position;

   assign year_x       = (st.year << 3) + (st.year << 1) + 14'(dv);
   assign month_x      = acc10(10'(st.month), dv);
   assign day_x        = acc10(10'(st.day), dv);
   assign hour_x       = acc10(10'(st.hour), dv);
   assign minute_x     = acc10(10'(st.minute), dv);
   assign second_x     = acc10(10'(st.second), dv);
   assign ofs_hour_x   = acc10(10'(st.ofs_hour), dv);
   assign ofs_minute_x = acc10(10'(st.ofs_minute), dv);
   assign frac_x       = (st.frac << 3) + (st.frac << 1) + 30'(dv);

   // divisible by 4, and not a century unless the century is divisible by 4
   assign leap = (st.year_mod4 == 2'd0) && (st.low_nonzero || (st.cent_mod4 == 2'd0));
   assign date_good = (st.year != 14'd0) && (st.month != 4'd0) && (day_x != 10'd0)
                      && (day_x <= 10'(days_in_month(st.month, leap)));

   always_comb begin
      nx = st;
      ok = 1'b1;
      unique case (st.phase)
         PH_DATE: begin
            if (pos == 6'd4 || pos == 6'd7) begin
               ok = (ch == CH_DASH);
            end else if (pos < 6'd4) begin
               ok = is_dig;
               nx.year = year_x;
               nx.year_mod4 = {st.year_mod4[0], 1'b0} + dv[1:0];
               if (pos == 6'd2) nx.cent_mod4 = st.year_mod4;
               if (pos >= 6'd2) nx.low_nonzero = st.low_nonzero | (dv != 4'd0);
            end else if (pos < 6'd7) begin
               ok = is_dig && (month_x <= 10'd12);
               nx.month = month_x[3:0];
            end else begin
               ok = is_dig && (day_x <= 10'd31);
               nx.day = day_x[4:0];
               if (pos == 6'd9) begin
                  nx.phase = PH_TIME;
                  ok = ok && date_good;
               end
            end
         end
         PH_TIME: begin
            if (pos == 6'd10) begin
               ok = (ch == CH_T);
            end else if (pos == 6'd13 || pos == 6'd16) begin
               ok = (ch == CH_COLON);
            end else if (pos < 6'd13) begin
               ok = is_dig && (hour_x < 10'd24);
               nx.hour = hour_x[4:0];
            end else if (pos < 6'd16) begin
               ok = is_dig && (minute_x < 10'd60);
               nx.minute = minute_x[5:0];
            end else begin
               ok = is_dig && (second_x <= 10'd60);
               nx.second = second_x[5:0];
               if (pos == 6'd18) nx.phase = PH_AFTER;
            end
         end
         PH_AFTER: begin
            if (ch == CH_DOT) begin
               nx.phase = PH_FRAC;
            end else if (is_z) begin
               nx.phase = PH_ZULU;
            end else if (is_sign) begin
               nx.phase = PH_OFFSET;
               nx.ofs_sign = (ch == CH_DASH);
               nx.ofs_pos = 3'd0;
            end else begin
               ok = 1'b0;
            end
         end
         PH_FRAC: begin
            if (is_dig) begin
               ok = (st.frac_count < MAX_FRACTION_DIGITS);
               nx.frac = frac_x;
               nx.frac_count = st.frac_count + 4'd1;
            end else if (st.frac_count == 4'd0) begin
               ok = 1'b0;
            end else if (is_z) begin
               nx.phase = PH_ZULU;
            end else if (is_sign) begin
               nx.phase = PH_OFFSET;
               nx.ofs_sign = (ch == CH_DASH);
               nx.ofs_pos = 3'd0;
            end else begin
               ok = 1'b0;
            end
         end
         PH_OFFSET: begin
            if (st.ofs_pos >= 3'd5) begin
               ok = 1'b0;
            end else begin
               nx.ofs_pos = st.ofs_pos + 3'd1;
               if (st.ofs_pos == 3'd2) begin
                  ok = (ch == CH_COLON);
               end else if (st.ofs_pos < 3'd2) begin
                  ok = is_dig && (ofs_hour_x <= 10'd23);
                  nx.ofs_hour = ofs_hour_x[4:0];
               end else begin
                  ok = is_dig && (ofs_minute_x <= 10'd59);
                  nx.ofs_minute = ofs_minute_x[5:0];
               end
            end
         end
         default: begin
            // zulu takes no further bytes
            ok = 1'b0;
         end
      endcase

      // once failed, bytes are ignored until the final one
      if (st.failed) nx = st;
      nx.failed   = st.failed | (pos >= MAX_TEXT) | ~ok;
      nx.position = (pos == POS_MAX) ? pos : pos + 6'd1;
   end

   assign st_next = nx;

   always_comb begin
      res_ok   = 1'b0;
      res_form = FORM_DATE;
      if (!nx.failed) begin
         if (nx.phase == PH_TIME && nx.position == 6'd10) begin
            res_ok = 1'b1;
         end else if (nx.phase == PH_AFTER) begin
            res_ok = 1'b1;
            res_form = FORM_TIME;
         end else if (nx.phase == PH_FRAC && nx.frac_count != 4'd0) begin
            res_ok = 1'b1;
            res_form = FORM_TIME;
         end else if (nx.phase == PH_ZULU) begin
            res_ok = 1'b1;
            res_form = FORM_OFFSET;
         end else if (nx.phase == PH_OFFSET && nx.ofs_pos == 3'd5) begin
            res_ok = 1'b1;
            res_form = FORM_OFFSET;
         end
      end

      result = '0;
      if (res_ok) begin
         result.valid_res = 1'b1;
         result.form  = res_form;
         result.year  = nx.year;
         result.month = nx.month;
         result.day   = nx.day;
         if (res_form != FORM_DATE) begin
            result.hour            = nx.hour;
            result.minute          = nx.minute;
            result.second          = nx.second;
            result.fraction        = nx.frac;
            result.fraction_digits = nx.frac_count;
         end
         if (nx.phase == PH_OFFSET) begin
            result.offset_negative = nx.ofs_sign;
            // hours times 60 as 64h - 4h
            result.offset_minutes  = 11'({nx.ofs_hour, 6'd0}) - 11'({nx.ofs_hour, 2'd0})
                                     + 11'(nx.ofs_minute);
         end
      end
   end

endmodule

// File: dv/tb_top.sv
// testbench for the streaming date-time text validator: byte stimulus, result predictor and checks
`timescale 1ns / 100ps

module tb_top
   import idsv_pkg::*;
();

   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam int unsigned QUIET_LIMIT = 2000;

   class datetime_scoreboard;
      int unsigned tpos, yr, mon, dy, hr, mi, se, frac, fcnt, opos, ohr, omi;
      logic [2:0] stage;
      bit broken, osign;
      rsp_payload_type pending[$];
      int errors;

      function new();
         errors = 0;
         clear_state();
      endfunction

      function void clear_state();
         tpos = 0; stage = PH_DATE; broken = 0;
         yr = 0; mon = 0; dy = 0; hr = 0; mi = 0; se = 0;
         frac = 0; fcnt = 0; opos = 0; osign = 0; ohr = 0; omi = 0;
      endfunction

      function int unsigned month_limit(int unsigned y, int unsigned m);
         int unsigned lim;
         case (m)
            4, 6, 9, 11: lim = 30;
            2:           lim = 28;
            default:     lim = 31;
         endcase
         if (m == 2 && y % 4 == 0 && (y % 100 != 0 || y % 400 == 0)) lim++;
         return lim;
      endfunction

      function bit open_offset(logic [7:0] c);
         if (c == CH_Z) begin
            stage = PH_ZULU;
            return 1;
         end
         if (c == CH_PLUS || c == CH_DASH) begin
            stage = PH_OFFSET;
            osign = (c == CH_DASH);
            opos = 0;
            return 1;
         end
         return 0;
      endfunction

      function bit parse_byte(logic [7:0] c);
         bit dig;
         int unsigned d, q;
         dig = (c >= CH_ZERO && c <= CH_NINE);
         d = c - CH_ZERO;
         case (stage)
            PH_DATE: begin
               if (tpos == 4 || tpos == 7) return c == CH_DASH;
               if (!dig) return 0;
               if (tpos < 4) begin
                  yr = yr * 10 + d;
                  return 1;
               end
               if (tpos < 7) begin
                  mon = mon * 10 + d;
                  return mon <= 12;
               end
               dy = dy * 10 + d;
               if (dy > 31) return 0;
               if (tpos == 9) begin
                  stage = PH_TIME;
                  return yr >= 1 && mon >= 1 && mon <= 12 && dy >= 1
                         && dy <= month_limit(yr, mon);
               end
               return 1;
            end
            PH_TIME: begin
               if (tpos == 10) return c == CH_T;
               if (tpos == 13 || tpos == 16) return c == CH_COLON;
               if (!dig) return 0;
               if (tpos < 13) begin
                  hr = hr * 10 + d;
                  return hr < 24;
               end
               if (tpos < 16) begin
                  mi = mi * 10 + d;
                  return mi < 60;
               end
               se = se * 10 + d;
               if (tpos == 18) stage = PH_AFTER;
               return se <= 60;
            end
            PH_AFTER: begin
               if (c == CH_DOT) begin
                  stage = PH_FRAC;
                  return 1;
               end
               return open_offset(c);
            end
            PH_FRAC: begin
               if (dig) begin
                  if (fcnt >= MAX_FRACTION_DIGITS) return 0;
                  frac = frac * 10 + d;
                  fcnt++;
                  return 1;
               end
               if (fcnt == 0) return 0;
               return open_offset(c);
            end
            PH_OFFSET: begin
               q = opos;
               if (q >= 5) return 0;
               opos = q + 1;
               if (q == 2) return c == CH_COLON;
               if (!dig) return 0;
               if (q < 2) begin
                  ohr = ohr * 10 + d;
                  return ohr <= 23;
               end
               omi = omi * 10 + d;
               return omi <= 59;
            end
            default: return 0;
         endcase
      endfunction

      // called for every accepted request beat
      function void note_byte(req_payload_type b);
         rsp_payload_type want;
         bit ok;
         logic [1:0] shape;
         int unsigned ofs;
         if (!broken) begin
            if (tpos >= MAX_TEXT || !parse_byte(b.char_byte)) broken = 1;
         end
         if (tpos < POS_MAX) tpos++;
         if (!b.last) return;
         ok = 0;
         shape = FORM_DATE;
         if (!broken) begin
            if (stage == PH_TIME && tpos == 10) ok = 1;
            else if (stage == PH_AFTER) begin
               ok = 1; shape = FORM_TIME;
            end else if (stage == PH_FRAC && fcnt > 0) begin
               ok = 1; shape = FORM_TIME;
            end else if (stage == PH_ZULU) begin
               ok = 1; shape = FORM_OFFSET;
            end else if (stage == PH_OFFSET && opos == 5) begin
               ok = 1; shape = FORM_OFFSET;
            end
         end
         want = '0;
         if (ok) begin
            want.valid_res = 1'b1;
            want.form = shape;
            want.year = yr[13:0];
            want.month = mon[3:0];
            want.day = dy[4:0];
            if (shape != FORM_DATE) begin
               want.hour = hr[4:0];
               want.minute = mi[5:0];
               want.second = se[5:0];
               want.fraction = frac[29:0];
               want.fraction_digits = fcnt[3:0];
            end
            // zulu leaves the offset fields at zero
            if (stage == PH_OFFSET) begin
               ofs = ohr * 60 + omi;
               want.offset_negative = osign;
               want.offset_minutes = ofs[10:0];
            end
         end
         pending.push_back(want);
         clear_state();
      endfunction

      function void field_diff(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (pending.size() == 0) begin
            $display("%0t: result beat with nothing expected, got %p", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         field_diff("valid_res", want.valid_res, got.valid_res);
         field_diff("form", want.form, got.form);
         field_diff("year", want.year, got.year);
         field_diff("month", want.month, got.month);
         field_diff("day", want.day, got.day);
         field_diff("hour", want.hour, got.hour);
         field_diff("minute", want.minute, got.minute);
         field_diff("second", want.second, got.second);
         field_diff("fraction", want.fraction, got.fraction);
         field_diff("fraction_digits", want.fraction_digits, got.fraction_digits);
         field_diff("offset_negative", want.offset_negative, got.offset_negative);
         field_diff("offset_minutes", want.offset_minutes, got.offset_minutes);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   datetime_scoreboard sb = new();
   logic [7:0] text_q[$];
   bit calm_tail = 0;
   int unsigned rand_bytes = 0;
   int unsigned rand_texts = 0;

   string directed_texts[] = '{
      "0001-01-01",
      "9999-12-31T23:59:60.999999999-23:59",
      "9999-12-31T23:59:60.999999999+23:590",
      "2000-02-29T00:00:00Z",
      "1900-02-29",
      "2024-02-29T12:30:45.5+05:30",
      "2023-04-31",
      "0000-01-01",
      "2023-13-01",
      "2023-06-15T10:20:30.",
      "2023-06-15T10:20:30.1234567890",
      "2023-06-15T24:00:00",
      "2023-06-15T10:60:00",
      "2023-06-15T10:00:61",
      "2023-06-15t10:20:30",
      "2023-06-15T10:20:30Zx",
      "2023-06-15T10:20:30+24:00",
      "2023-06-15T10:20:30-05:3",
      "2023-06-15T10:20",
      "2023-x6-15T10:20:30Z"
   };

   iso_datetime_stream_validator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void push_num(int unsigned v, int digits);
      int unsigned scale;
      scale = 1;
      repeat (digits - 1) scale *= 10;
      repeat (digits) begin
         text_q.push_back(CH_ZERO + 8'((v / scale) % 10));
         scale /= 10;
      end
   endfunction

   // mostly in range, often on a boundary, now and then just past top
   function automatic int unsigned near_range(int unsigned top);
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return $urandom_range(top + 1, top + 9);
      if (r < 3) return top;
      if (r < 5) return 0;
      return $urandom_range(0, top);
   endfunction

   function automatic void make_text();
      int unsigned y, m, d, lim, n, shape, r;
      text_q.delete();
      if ($urandom_range(0, 99) < 8) begin
         n = $urandom_range(1, 40);
         repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      r = $urandom_range(0, 9);
      if (r == 0) y = 0;
      else if (r < 3) begin
         case ($urandom_range(0, 3))
            0: y = 1600;
            1: y = 1900;
            2: y = 2000;
            default: y = 4 * $urandom_range(1, 2499);
         endcase
      end else y = $urandom_range(1, 9999);
      if ($urandom_range(0, 19) == 0) m = $urandom_range(0, 1) ? 13 : 0;
      else m = $urandom_range(1, 12);
      lim = (m >= 1 && m <= 12) ? sb.month_limit(y, m) : 31;
      r = $urandom_range(0, 19);
      if (r == 0) d = 0;
      else if (r == 1) d = lim + 1;
      else if (r < 5) d = lim;
      else d = $urandom_range(1, lim);
      push_num(y, 4);
      text_q.push_back(CH_DASH);
      push_num(m, 2);
      text_q.push_back(CH_DASH);
      push_num(d, 2);
      shape = $urandom_range(0, 5);
      if (shape != 0) begin
         text_q.push_back(($urandom_range(0, 29) == 0) ? CH_LOWER_T : CH_T);
         push_num(near_range(23), 2);
         text_q.push_back(CH_COLON);
         push_num(near_range(59), 2);
         text_q.push_back(CH_COLON);
         push_num(near_range(60), 2);
         if (shape == 2 || shape == 5) begin
            text_q.push_back(CH_DOT);
            r = $urandom_range(0, 19);
            n = (r == 0) ? 0 : (r == 1) ? 10 : $urandom_range(1, 9);
            repeat (n) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
         end
         if (shape == 3 || (shape == 5 && $urandom_range(0, 2) == 0)) text_q.push_back(CH_Z);
         else if (shape >= 4) begin
            text_q.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
            push_num(near_range(23), 2);
            text_q.push_back(CH_COLON);
            push_num(near_range(59), 2);
         end
      end
      // damage a share of the texts: stray byte, cut short, or trailing junk
      r = $urandom_range(0, 99);
      if (r < 12) text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
      else if (r < 17) begin
         n = $urandom_range(1, text_q.size());
         text_q = text_q[0:n-1];
      end else if (r < 21) repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   task automatic send_text();
      bit gappy;
      gappy = !calm_tail && $urandom_range(0, 1);
      for (int i = 0; i < text_q.size(); i++) begin
         if (gappy && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_payload <= {text_q[i], i == text_q.size() - 1};
         do @(posedge clock); while (!req_ready);
         sb.note_byte(req_payload);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_texts[k]) begin
         text_q.delete();
         for (int j = 0; j < directed_texts[k].len(); j++) text_q.push_back(directed_texts[k][j]);
         send_text();
      end
      // sender holds off until every result is back
      drain_results();
      while (rand_bytes < 140 || rand_texts < 6) begin
         make_text();
         send_text();
         rand_bytes += text_q.size();
         rand_texts++;
      end
      calm_tail = 1;
      repeat (8) begin
         make_text();
         send_text();
      end
      drain_results();
      repeat (20) @(posedge clock);
      if (sb.errors == 0) $display("tb_top: PASS");
      else $display("tb_top: FAIL");
      $finish;
   end

   initial begin : result_sink
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm_tail && $urandom_range(0, 6) == 0) stall = $urandom_range(1, 17);
         end
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
